@@ rtl/perspective_viewport_projection_core_defines.svh @@
// ----------------------------------------------------------------------------
// perspective viewport projection assertion macros
// shared concurrent check forms for the projection core
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_VIEWPORT_PROJECTION_CORE_DEFINES_SVH
`define PERSPECTIVE_VIEWPORT_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define PVP_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define PVP_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pvp_pkg.sv @@
// ----------------------------------------------------------------------------
// pvp_pkg
// types and fixed constants of the perspective viewport projection core
// ----------------------------------------------------------------------------
package pvp_pkg;

  // coordinate word width, fixed by the item layout
  localparam int COORD_W = 32;

  // configuration register width and index width
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd480;

  // input item
  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic signed [COORD_W-1:0] depth;
    logic                      zero_depth_fault;
    logic                      saturated;
  } out_t;

  // per-item control travelling with the pipeline
  typedef struct packed {
    logic               valid;
    logic               fault;
    logic               x_neg;
    logic               y_neg;
    logic               x_ovf;
    logic               y_ovf;
    logic [COORD_W-1:0] depth;
  } side_t;

endpackage

@@ rtl/perspective_viewport_projection_core.sv @@
// ----------------------------------------------------------------------------
// perspective_viewport_projection_core
// perspective divide by depth and viewport mapping of one vertex per clock
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  vertex    in         start high, busy low      in_t  (x, y, z)
//  result    out        done strobe, one cycle    out_t (screen x/y, depth, flags)
//  config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
//  one item enters every clock in which busy is low; the divider width is
//  QW = max(COORD_W + 1, FRAC_BITS + 14) + 1
//  the restoring divider has QW stages, one quotient bit each
//  reset clears all stage valid bits, loads width 640 and height 480, and
//  holds busy high for the cycle after reset
//  results cannot be held off, so the pipeline never stalls
// ----------------------------------------------------------------------------
`include "perspective_viewport_projection_core_defines.svh"

module perspective_viewport_projection_core import pvp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  vertex,
  output logic                 done,
  output out_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int QA  = COORD_W + 1;
  localparam int QB  = FRAC_BITS + CFG_W;
  localparam int QW  = ((QA > QB) ? QA : QB) + 1;
  localparam int LAT = QW + 4;

  logic             accept;
  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;

  side_t              side_c    [QW+1];
  logic [COORD_W-1:0] divisor_c [QW+1];
  logic [COORD_W-1:0] rem_x_c   [QW+1];
  logic [COORD_W-1:0] rem_y_c   [QW+1];
  logic [QW-1:0]      lq_x_c    [QW+1];
  logic [QW-1:0]      lq_y_c    [QW+1];

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // busy during reset and in the cycle that follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // viewport registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front stages
  pvp_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .vertex       (vertex),
    .screen_width (screen_width),
    .side         (side_c[0]),
    .divisor      (divisor_c[0]),
    .rem_x        (rem_x_c[0]),
    .lq_x         (lq_x_c[0]),
    .rem_y        (rem_y_c[0]),
    .lq_y         (lq_y_c[0])
  );

  // divider chain
  for (genvar i = 0; i < QW; i++) begin : g_div
    pvp_div_step #(.QW(QW)) u_step (
      .clk         (clk),
      .rst         (rst),
      .side_in     (side_c[i]),
      .divisor_in  (divisor_c[i]),
      .rem_x_in    (rem_x_c[i]),
      .lq_x_in     (lq_x_c[i]),
      .rem_y_in    (rem_y_c[i]),
      .lq_y_in     (lq_y_c[i]),
      .side_out    (side_c[i+1]),
      .divisor_out (divisor_c[i+1]),
      .rem_x_out   (rem_x_c[i+1]),
      .lq_x_out    (lq_x_c[i+1]),
      .rem_y_out   (rem_y_c[i+1]),
      .lq_y_out    (lq_y_c[i+1])
    );
  end

  // output stage
  pvp_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .side          (side_c[QW]),
    .quot_x        (lq_x_c[QW]),
    .quot_y        (lq_y_c[QW]),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .done          (done),
    .result        (result)
  );

  // checks
  `PVP_ASSERT_IMP(a_done_follows_accept, clk, rst, done,
    $past(accept, LAT), "result without an item")
  `PVP_ASSERT_IMP(a_depth_through, clk, rst, done,
    result.depth == $past(vertex.vertex_z, LAT), "depth altered")
  `PVP_ASSERT_IMP(a_fault_zero, clk, rst, done && result.zero_depth_fault,
    result.screen_x == '0 && result.screen_y == '0 && !result.saturated,
    "zero depth item not cleared")
  `PVP_ASSERT_NXT(a_cfg_width, clk, rst,
    cfg_valid && cfg_ready && cfg_index == REG_WIDTH,
    screen_width == $past(cfg_data), "width write lost")

endmodule

@@ rtl/pvp_front.sv @@
// ----------------------------------------------------------------------------
// pvp_front
// three input stages: magnitudes, width product, divider set-up
// ----------------------------------------------------------------------------
module pvp_front import pvp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  in_t                vertex,
  input  logic [CFG_W-1:0]   screen_width,
  output side_t              side,
  output logic [COORD_W-1:0] divisor,
  output logic [COORD_W-1:0] rem_x,
  output logic [QW-1:0]      lq_x,
  output logic [COORD_W-1:0] rem_y,
  output logic [QW-1:0]      lq_y
);

  localparam int NW = COORD_W + CFG_W;
  localparam int MW = NW + FRAC_BITS - 1;
  localparam int HW = MW - QW;
  localparam int CW = (HW > COORD_W) ? HW : COORD_W;

  side_t              side1;
  logic [COORD_W-1:0] mag_x;
  logic [COORD_W-1:0] mag_y;
  logic [COORD_W-1:0] mag_z;
  logic [COORD_W-1:0] raw_x;
  logic [COORD_W-1:0] raw_y;
  logic [COORD_W-1:0] raw_z;

  side_t              side2;
  logic [NW-1:0]      prod_x;
  logic [NW-1:0]      prod_y;
  logic [COORD_W-1:0] mag_z2;

  logic [MW-1:0]      num_x;
  logic [MW-1:0]      num_y;
  logic [HW-1:0]      top_x;
  logic [HW-1:0]      top_y;
  logic               ovf_x;
  logic               ovf_y;

  assign raw_x = vertex.vertex_x;
  assign raw_y = vertex.vertex_y;
  assign raw_z = vertex.vertex_z;

  // stage 1: signs, zero depth, magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      side1.valid <= 1'b0;
    end else begin
      side1.valid <= load;
    end
    side1.fault <= (raw_z == '0);
    side1.x_neg <= raw_x[COORD_W-1] ^ raw_z[COORD_W-1];
    side1.y_neg <= raw_y[COORD_W-1] ^ raw_z[COORD_W-1];
    side1.x_ovf <= 1'b0;
    side1.y_ovf <= 1'b0;
    side1.depth <= raw_z;
    mag_x <= raw_x[COORD_W-1] ? (~raw_x + 1'b1) : raw_x;
    mag_y <= raw_y[COORD_W-1] ? (~raw_y + 1'b1) : raw_y;
    mag_z <= raw_z[COORD_W-1] ? (~raw_z + 1'b1) : raw_z;
  end

  // stage 2: scale both magnitudes by the viewport width
  always_ff @(posedge clk) begin
    if (rst) begin
      side2.valid <= 1'b0;
    end else begin
      side2.valid <= side1.valid;
    end
    side2.fault <= side1.fault;
    side2.x_neg <= side1.x_neg;
    side2.y_neg <= side1.y_neg;
    side2.x_ovf <= side1.x_ovf;
    side2.y_ovf <= side1.y_ovf;
    side2.depth <= side1.depth;
    prod_x <= {{CFG_W{1'b0}}, mag_x} * {{COORD_W{1'b0}}, screen_width};
    prod_y <= {{CFG_W{1'b0}}, mag_y} * {{COORD_W{1'b0}}, screen_width};
    mag_z2 <= mag_z;
  end

  // numerator with the half-unit scale; quotient too wide for QW bits is overflow
  assign num_x = {prod_x, {(FRAC_BITS-1){1'b0}}};
  assign num_y = {prod_y, {(FRAC_BITS-1){1'b0}}};
  assign top_x = num_x[MW-1:QW];
  assign top_y = num_y[MW-1:QW];
  assign ovf_x = (CW'(top_x) >= CW'(mag_z2));
  assign ovf_y = (CW'(top_y) >= CW'(mag_z2));

  // stage 3: load the long-division remainders and dividend tails
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= side2.valid;
    end
    side.fault <= side2.fault;
    side.x_neg <= side2.x_neg;
    side.y_neg <= side2.y_neg;
    side.x_ovf <= ovf_x;
    side.y_ovf <= ovf_y;
    side.depth <= side2.depth;
    divisor    <= mag_z2;
    rem_x      <= COORD_W'(top_x);
    rem_y      <= COORD_W'(top_y);
    lq_x       <= num_x[QW-1:0];
    lq_y       <= num_y[QW-1:0];
  end

endmodule

@@ rtl/pvp_div_step.sv @@
// ----------------------------------------------------------------------------
// pvp_div_step
// one restoring division stage: one quotient bit for each of x and y
// ----------------------------------------------------------------------------
module pvp_div_step import pvp_pkg::*; #(
  parameter int QW = 34
) (
  input  logic               clk,
  input  logic               rst,
  input  side_t              side_in,
  input  logic [COORD_W-1:0] divisor_in,
  input  logic [COORD_W-1:0] rem_x_in,
  input  logic [QW-1:0]      lq_x_in,
  input  logic [COORD_W-1:0] rem_y_in,
  input  logic [QW-1:0]      lq_y_in,
  output side_t              side_out,
  output logic [COORD_W-1:0] divisor_out,
  output logic [COORD_W-1:0] rem_x_out,
  output logic [QW-1:0]      lq_x_out,
  output logic [COORD_W-1:0] rem_y_out,
  output logic [QW-1:0]      lq_y_out
);

  logic [COORD_W:0] trial_x;
  logic [COORD_W:0] trial_y;
  logic [COORD_W:0] diff_x;
  logic [COORD_W:0] diff_y;
  logic             take_x;
  logic             take_y;

  // shift in the next dividend bit and try the subtract
  assign trial_x = {rem_x_in, lq_x_in[QW-1]};
  assign trial_y = {rem_y_in, lq_y_in[QW-1]};
  assign diff_x  = trial_x - {1'b0, divisor_in};
  assign diff_y  = trial_y - {1'b0, divisor_in};
  assign take_x  = (trial_x >= {1'b0, divisor_in});
  assign take_y  = (trial_y >= {1'b0, divisor_in});

  // stage register; quotient bits enter where dividend bits leave
  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.fault <= side_in.fault;
    side_out.x_neg <= side_in.x_neg;
    side_out.y_neg <= side_in.y_neg;
    side_out.x_ovf <= side_in.x_ovf;
    side_out.y_ovf <= side_in.y_ovf;
    side_out.depth <= side_in.depth;
    divisor_out    <= divisor_in;
    rem_x_out      <= take_x ? diff_x[COORD_W-1:0] : trial_x[COORD_W-1:0];
    rem_y_out      <= take_y ? diff_y[COORD_W-1:0] : trial_y[COORD_W-1:0];
    lq_x_out       <= {lq_x_in[QW-2:0], take_x};
    lq_y_out       <= {lq_y_in[QW-2:0], take_y};
  end

endmodule

@@ rtl/pvp_back.sv @@
// ----------------------------------------------------------------------------
// pvp_back
// output stage: sign, viewport centre offset, saturation and zero-depth rule
// ----------------------------------------------------------------------------
module pvp_back import pvp_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  side_t            side,
  input  logic [QW-1:0]    quot_x,
  input  logic [QW-1:0]    quot_y,
  input  logic [CFG_W-1:0] screen_width,
  input  logic [CFG_W-1:0] screen_height,
  output logic             done,
  output out_t             result
);

  localparam int SW = QW + 2;
  localparam logic signed [SW-1:0] SAT_HI =
    $signed({{(SW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO =
    $signed({{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});

  logic [COORD_W:0] proj_x;
  logic [COORD_W:0] proj_y;

  // signed term plus centre offset, clamped; top bit marks a clamp
  function automatic logic [COORD_W:0] project(
    input logic [QW-1:0]    quot,
    input logic             neg,
    input logic             ovf,
    input logic [CFG_W-1:0] centre
  );
    logic signed [SW-1:0] term;
    logic        [SW-1:0] offset;
    logic signed [SW-1:0] sum;
    logic        [COORD_W:0] res;
    term   = $signed({2'b00, quot});
    if (neg) begin
      term = -term;
    end
    offset = SW'({centre, {(FRAC_BITS-1){1'b0}}});
    sum    = term + $signed(offset);
    if (ovf) begin
      res = neg ? {1'b1, SAT_LO[COORD_W-1:0]} : {1'b1, SAT_HI[COORD_W-1:0]};
    end else if (sum > SAT_HI) begin
      res = {1'b1, SAT_HI[COORD_W-1:0]};
    end else if (sum < SAT_LO) begin
      res = {1'b1, SAT_LO[COORD_W-1:0]};
    end else begin
      res = {1'b0, sum[COORD_W-1:0]};
    end
    return res;
  endfunction

  assign proj_x = project(quot_x, side.x_neg, side.x_ovf, screen_width);
  assign proj_y = project(quot_y, side.y_neg, side.y_ovf, screen_height);

  // result register; zero depth forces the coordinates to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side.valid;
    end
    result.screen_x         <= side.fault ? '0 : proj_x[COORD_W-1:0];
    result.screen_y         <= side.fault ? '0 : proj_y[COORD_W-1:0];
    result.depth            <= side.depth;
    result.zero_depth_fault <= side.fault;
    result.saturated        <= !side.fault && (proj_x[COORD_W] || proj_y[COORD_W]);
  end

endmodule
